[design/i2cbb_pkg.sv]
// Package with the shared types and constants of the I2C bit-bang master.
`timescale 1ns / 1ps

package i2cbb_pkg;

    // Command codes carried in the action field.
    localparam logic [2:0] ACT_TICK  = 3'd0;
    localparam logic [2:0] ACT_START = 3'd1;
    localparam logic [2:0] ACT_STOP  = 3'd2;
    localparam logic [2:0] ACT_WRITE = 3'd3;
    localparam logic [2:0] ACT_READ  = 3'd4;

    // Selects the bit that goes out first on a write.
    localparam logic [7:0] MSB_MASK = 8'h80;

    // Number of data bits in one byte transfer.
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    // Line phases of the sequencer, one-hot coded.
    typedef enum logic [24:0] {
        PH_IDLE       = 25'h0000001,
        PH_STA_SCL_LO = 25'h0000002,
        PH_STA_SDA_HI = 25'h0000004,
        PH_STA_SCL_HI = 25'h0000008,
        PH_STA_SDA_LO = 25'h0000010,
        PH_STA_END    = 25'h0000020,
        PH_STO_SCL_LO = 25'h0000040,
        PH_STO_SDA_LO = 25'h0000080,
        PH_STO_SCL_HI = 25'h0000100,
        PH_STO_END    = 25'h0000200,
        PH_WR_SCL_LO  = 25'h0000400,
        PH_WR_SDA     = 25'h0000800,
        PH_WR_SCL_HI  = 25'h0001000,
        PH_WA_SCL_LO  = 25'h0002000,
        PH_WA_SDA_HI  = 25'h0004000,
        PH_WA_SAMPLE  = 25'h0008000,
        PH_WA_END     = 25'h0010000,
        PH_RD_SDA_HI  = 25'h0020000,
        PH_RD_SCL_LO  = 25'h0040000,
        PH_RD_SAMPLE  = 25'h0080000,
        PH_RA_SCL_LO  = 25'h0100000,
        PH_RA_SDA     = 25'h0200000,
        PH_RA_SCL_HI  = 25'h0400000,
        PH_RA_SCL_LO2 = 25'h0800000,
        PH_RA_END     = 25'h1000000
    } phase_t;

    // One input transaction as seen by the sequencer.
    typedef struct packed {
        logic [2:0] action;
        logic [7:0] write_byte;
        logic       read_is_last;
        logic       scl_level;
        logic       sda_level;
    } cmd_t;

    // One result transaction.
    typedef struct packed {
        logic       acknowledged;
        logic [7:0] read_byte;
        logic       done_res;
        logic       busy_res;
        logic       sda_drive;
        logic       scl_drive;
    } result_t;

endpackage

[design/i2cbb_seq.sv]
// Line sequencer of the I2C bit-bang master: one phase step per accepted transaction.
`timescale 1ns / 1ps

module i2cbb_seq (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step_en,
    input  i2cbb_pkg::cmd_t    cmd,
    output i2cbb_pkg::result_t result
);

    i2cbb_pkg::phase_t phase_reg, phase_next;
    logic [3:0] bit_count_reg, bit_count_next;
    logic [7:0] shift_byte_reg, shift_byte_next;
    logic [2:0] command_kind_reg, command_kind_next;
    logic       nak_on_read_reg, nak_on_read_next;
    logic       scl_out_reg, scl_out_next;
    logic       sda_out_reg, sda_out_next;
    logic       ack_seen_reg, ack_seen_next;
    logic [7:0] read_hold_reg, read_hold_next;
    logic       done;
    logic [3:0] bit_count_inc;
    logic [7:0] shift_in;

    assign bit_count_inc = bit_count_reg + 4'd1;
    assign shift_in      = {shift_byte_reg[6:0], cmd.sda_level};

    // Next phase and line levels for one step.
    always_comb begin
        phase_next        = phase_reg;
        bit_count_next    = bit_count_reg;
        shift_byte_next   = shift_byte_reg;
        command_kind_next = command_kind_reg;
        nak_on_read_next  = nak_on_read_reg;
        scl_out_next      = scl_out_reg;
        sda_out_next      = sda_out_reg;
        ack_seen_next     = ack_seen_reg;
        read_hold_next    = read_hold_reg;
        done              = 1'b0;
        unique case (phase_reg)
            i2cbb_pkg::PH_IDLE: begin
                // Only a command leaves idle; it latches and changes no line.
                unique case (cmd.action)
                    i2cbb_pkg::ACT_START: begin
                        command_kind_next = cmd.action;
                        bit_count_next    = '0;
                        phase_next        = i2cbb_pkg::PH_STA_SCL_LO;
                    end
                    i2cbb_pkg::ACT_STOP: begin
                        command_kind_next = cmd.action;
                        bit_count_next    = '0;
                        phase_next        = i2cbb_pkg::PH_STO_SCL_LO;
                    end
                    i2cbb_pkg::ACT_WRITE: begin
                        command_kind_next = cmd.action;
                        bit_count_next    = '0;
                        shift_byte_next   = cmd.write_byte;
                        phase_next        = i2cbb_pkg::PH_WR_SCL_LO;
                    end
                    i2cbb_pkg::ACT_READ: begin
                        command_kind_next = cmd.action;
                        bit_count_next    = '0;
                        shift_byte_next   = '0;
                        nak_on_read_next  = cmd.read_is_last;
                        phase_next        = i2cbb_pkg::PH_RD_SDA_HI;
                    end
                    default: begin
                    end
                endcase
            end
            // Start condition.
            i2cbb_pkg::PH_STA_SCL_LO: begin
                scl_out_next = 1'b0;
                phase_next   = i2cbb_pkg::PH_STA_SDA_HI;
            end
            i2cbb_pkg::PH_STA_SDA_HI: begin
                sda_out_next = 1'b1;
                phase_next   = i2cbb_pkg::PH_STA_SCL_HI;
            end
            i2cbb_pkg::PH_STA_SCL_HI: begin
                scl_out_next = 1'b1;
                if (cmd.scl_level) begin
                    phase_next = i2cbb_pkg::PH_STA_SDA_LO;
                end
            end
            i2cbb_pkg::PH_STA_SDA_LO: begin
                sda_out_next = 1'b0;
                phase_next   = i2cbb_pkg::PH_STA_END;
            end
            i2cbb_pkg::PH_STA_END: begin
                scl_out_next = 1'b0;
                phase_next   = i2cbb_pkg::PH_IDLE;
                done         = 1'b1;
            end
            // Stop condition.
            i2cbb_pkg::PH_STO_SCL_LO: begin
                scl_out_next = 1'b0;
                phase_next   = i2cbb_pkg::PH_STO_SDA_LO;
            end
            i2cbb_pkg::PH_STO_SDA_LO: begin
                sda_out_next = 1'b0;
                phase_next   = i2cbb_pkg::PH_STO_SCL_HI;
            end
            i2cbb_pkg::PH_STO_SCL_HI: begin
                scl_out_next = 1'b1;
                if (cmd.scl_level) begin
                    phase_next = i2cbb_pkg::PH_STO_END;
                end
            end
            i2cbb_pkg::PH_STO_END: begin
                sda_out_next = 1'b1;
                phase_next   = i2cbb_pkg::PH_IDLE;
                done         = 1'b1;
            end
            // Write bits, MSB first; the byte rotates so the next bit sits on top.
            i2cbb_pkg::PH_WR_SCL_LO: begin
                scl_out_next = 1'b0;
                phase_next   = i2cbb_pkg::PH_WR_SDA;
            end
            i2cbb_pkg::PH_WR_SDA: begin
                sda_out_next    = (shift_byte_reg & i2cbb_pkg::MSB_MASK) != 8'd0;
                shift_byte_next = {shift_byte_reg[6:0], shift_byte_reg[7]};
                phase_next      = i2cbb_pkg::PH_WR_SCL_HI;
            end
            i2cbb_pkg::PH_WR_SCL_HI: begin
                scl_out_next = 1'b1;
                if (cmd.scl_level) begin
                    bit_count_next = bit_count_inc;
                    phase_next     = (bit_count_inc >= i2cbb_pkg::BITS_PER_BYTE) ?
                                     i2cbb_pkg::PH_WA_SCL_LO : i2cbb_pkg::PH_WR_SCL_LO;
                end
            end
            // Acknowledge from the slave.
            i2cbb_pkg::PH_WA_SCL_LO: begin
                scl_out_next = 1'b0;
                phase_next   = i2cbb_pkg::PH_WA_SDA_HI;
            end
            i2cbb_pkg::PH_WA_SDA_HI: begin
                sda_out_next = 1'b1;
                phase_next   = i2cbb_pkg::PH_WA_SAMPLE;
            end
            i2cbb_pkg::PH_WA_SAMPLE: begin
                scl_out_next = 1'b1;
                if (cmd.scl_level) begin
                    ack_seen_next = ~cmd.sda_level;
                    phase_next    = i2cbb_pkg::PH_WA_END;
                end
            end
            i2cbb_pkg::PH_WA_END: begin
                scl_out_next = 1'b0;
                phase_next   = i2cbb_pkg::PH_IDLE;
                done         = 1'b1;
            end
            // Read bits, sampled while the clock is high.
            i2cbb_pkg::PH_RD_SDA_HI: begin
                sda_out_next = 1'b1;
                phase_next   = i2cbb_pkg::PH_RD_SCL_LO;
            end
            i2cbb_pkg::PH_RD_SCL_LO: begin
                scl_out_next = 1'b0;
                phase_next   = i2cbb_pkg::PH_RD_SAMPLE;
            end
            i2cbb_pkg::PH_RD_SAMPLE: begin
                scl_out_next = 1'b1;
                if (cmd.scl_level) begin
                    shift_byte_next = shift_in;
                    bit_count_next  = bit_count_inc;
                    if (bit_count_inc >= i2cbb_pkg::BITS_PER_BYTE) begin
                        read_hold_next = shift_in;
                        phase_next     = i2cbb_pkg::PH_RA_SCL_LO;
                    end else begin
                        phase_next = i2cbb_pkg::PH_RD_SCL_LO;
                    end
                end
            end
            // Master ACK, or NAK on the last read.
            i2cbb_pkg::PH_RA_SCL_LO: begin
                scl_out_next = 1'b0;
                phase_next   = i2cbb_pkg::PH_RA_SDA;
            end
            i2cbb_pkg::PH_RA_SDA: begin
                sda_out_next = nak_on_read_reg;
                phase_next   = i2cbb_pkg::PH_RA_SCL_HI;
            end
            i2cbb_pkg::PH_RA_SCL_HI: begin
                scl_out_next = 1'b1;
                if (cmd.scl_level) begin
                    phase_next = i2cbb_pkg::PH_RA_SCL_LO2;
                end
            end
            i2cbb_pkg::PH_RA_SCL_LO2: begin
                scl_out_next = 1'b0;
                phase_next   = i2cbb_pkg::PH_RA_END;
            end
            i2cbb_pkg::PH_RA_END: begin
                sda_out_next = ~nak_on_read_reg;
                phase_next   = i2cbb_pkg::PH_IDLE;
                done         = 1'b1;
            end
            default: begin
                phase_next = i2cbb_pkg::PH_IDLE;
            end
        endcase
    end

    // Result of this step, taken by the output stage in the same cycle.
    always_comb begin
        result.scl_drive    = scl_out_next;
        result.sda_drive    = sda_out_next;
        result.busy_res     = (phase_next != i2cbb_pkg::PH_IDLE);
        result.done_res     = done;
        result.read_byte    = read_hold_next;
        result.acknowledged = ack_seen_next;
    end

    // State registers advance once per accepted transaction.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= i2cbb_pkg::PH_IDLE;
            bit_count_reg    <= '0;
            shift_byte_reg   <= '0;
            command_kind_reg <= '0;
            nak_on_read_reg  <= 1'b0;
            scl_out_reg      <= 1'b1;
            sda_out_reg      <= 1'b1;
            ack_seen_reg     <= 1'b0;
            read_hold_reg    <= '0;
        end else if (step_en) begin
            phase_reg        <= phase_next;
            bit_count_reg    <= bit_count_next;
            shift_byte_reg   <= shift_byte_next;
            command_kind_reg <= command_kind_next;
            nak_on_read_reg  <= nak_on_read_next;
            scl_out_reg      <= scl_out_next;
            sda_out_reg      <= sda_out_next;
            ack_seen_reg     <= ack_seen_next;
            read_hold_reg    <= read_hold_next;
        end
    end

endmodule

[design/i2c_bitbang_master_unit.sv]
// Top level of the I2C bit-bang master: stream ports, sequencer and output skid stage.
//
// Channel  | Direction | Ports                             | Contents
// ---------+-----------+-----------------------------------+----------------------------------
// s_       | in        | tvalid tready tdata tuser tlast   | one command or tick per transaction
// m_       | out       | tvalid tready tdata tlast         | line levels and status, one per input
//
// Each accepted input transaction yields exactly one result, held in a register of the output stage.
// A new input transaction can be taken every cycle while s_tready is high; the phase step is a single pass of
// logic from the sequencer state registers to the result register.
// Reset (aresetn low at a clock edge) puts the sequencer in idle with both lines high
// and empties the output stage.
// Output stalls are absorbed by a two-entry output stage; s_tready drops only once both
// entries hold results that have not been taken.
`timescale 1ns / 1ps

module i2c_bitbang_master_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] write_byte, [8] scl_level, [9] sda_level, [15:10] zero
    input  logic [15:0] s_tdata,
    // [2:0] action
    input  logic [2:0]  s_tuser,
    // read_is_last
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] scl_drive, [1] sda_drive, [2] busy_res, [10:3] read_byte, [11] acknowledged,
    // [15:12] zero
    output logic [15:0] m_tdata,
    // done_res
    output logic        m_tlast
);

    i2cbb_pkg::cmd_t    cmd;
    i2cbb_pkg::result_t step_result;
    i2cbb_pkg::result_t out_data_reg, skid_data_reg;
    logic               out_valid_reg, skid_valid_reg;
    logic               s_accept;
    logic               m_accept;

    assign s_tready = ~skid_valid_reg;
    assign s_accept = s_tvalid & s_tready;
    assign m_accept = out_valid_reg & m_tready;

    // Unpack the input transaction.
    always_comb begin
        cmd.action       = s_tuser;
        cmd.write_byte   = s_tdata[7:0];
        cmd.read_is_last = s_tlast;
        cmd.scl_level    = s_tdata[8];
        cmd.sda_level    = s_tdata[9];
    end

    i2cbb_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (s_accept),
        .cmd     (cmd),
        .result  (step_result)
    );

    // Output register with a skid entry behind it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (skid_valid_reg) begin
                if (m_accept) begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
            end else if (s_accept) begin
                if (out_valid_reg && !m_tready) begin
                    skid_valid_reg <= 1'b1;
                end else begin
                    out_valid_reg <= 1'b1;
                end
            end else if (m_accept) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload moves with the valid bits above.
    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_accept) begin
                out_data_reg <= skid_data_reg;
            end
        end else if (s_accept) begin
            if (out_valid_reg && !m_tready) begin
                skid_data_reg <= step_result;
            end else begin
                out_data_reg <= step_result;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_data_reg.acknowledged, out_data_reg.read_byte,
                       out_data_reg.busy_res, out_data_reg.sda_drive, out_data_reg.scl_drive};
    assign m_tlast  = out_data_reg.done_res;

endmodule

[sim/i2c_line_checker.sv]
// Checker that predicts and compares the result stream of the I2C bit-bang master.
`timescale 1ns / 1ps

module i2c_line_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic [2:0]  s_tuser,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic        m_tlast,
    output int          mismatch_count,
    output int          pending_count
);

    // Predicted sequencer state.
    i2cbb_pkg::phase_t line_phase;
    logic [3:0] bits_moved;
    logic [7:0] shift_reg;
    logic       send_nak;
    logic       scl_level_out;
    logic       sda_level_out;
    logic       slave_acked;
    logic [7:0] read_latch;

    // Expected line levels and status, oldest first.
    i2cbb_pkg::result_t line_levels_due[$];

    initial begin
        mismatch_count = 0;
        pending_count  = 0;
    end

    // Advances the predicted sequencer by one input transaction and returns its result.
    function automatic i2cbb_pkg::result_t advance_line_phase(input logic [2:0] act,
                                                              input logic [7:0] wbyte,
                                                              input logic       last,
                                                              input logic       scl_in,
                                                              input logic       sda_in);
        i2cbb_pkg::result_t r;
        logic               done;
        done = 1'b0;
        if (line_phase == i2cbb_pkg::PH_IDLE) begin
            // Only a known command leaves idle; the lines stay as they are on this transaction.
            case (act)
                i2cbb_pkg::ACT_START: begin
                    bits_moved = '0;
                    line_phase = i2cbb_pkg::PH_STA_SCL_LO;
                end
                i2cbb_pkg::ACT_STOP: begin
                    bits_moved = '0;
                    line_phase = i2cbb_pkg::PH_STO_SCL_LO;
                end
                i2cbb_pkg::ACT_WRITE: begin
                    bits_moved = '0;
                    shift_reg  = wbyte;
                    line_phase = i2cbb_pkg::PH_WR_SCL_LO;
                end
                i2cbb_pkg::ACT_READ: begin
                    bits_moved = '0;
                    shift_reg  = '0;
                    send_nak   = last;
                    line_phase = i2cbb_pkg::PH_RD_SDA_HI;
                end
                default: ;
            endcase
        end else begin
            // Any action while busy acts as a tick. Clock-high phases wait for the sensed clock.
            case (line_phase)
                i2cbb_pkg::PH_STA_SCL_LO: begin
                    scl_level_out = 1'b0;
                    line_phase    = i2cbb_pkg::PH_STA_SDA_HI;
                end
                i2cbb_pkg::PH_STA_SDA_HI: begin
                    sda_level_out = 1'b1;
                    line_phase    = i2cbb_pkg::PH_STA_SCL_HI;
                end
                i2cbb_pkg::PH_STA_SCL_HI: begin
                    scl_level_out = 1'b1;
                    if (scl_in) line_phase = i2cbb_pkg::PH_STA_SDA_LO;
                end
                i2cbb_pkg::PH_STA_SDA_LO: begin
                    sda_level_out = 1'b0;
                    line_phase    = i2cbb_pkg::PH_STA_END;
                end
                i2cbb_pkg::PH_STA_END: begin
                    scl_level_out = 1'b0;
                    line_phase    = i2cbb_pkg::PH_IDLE;
                    done          = 1'b1;
                end
                i2cbb_pkg::PH_STO_SCL_LO: begin
                    scl_level_out = 1'b0;
                    line_phase    = i2cbb_pkg::PH_STO_SDA_LO;
                end
                i2cbb_pkg::PH_STO_SDA_LO: begin
                    sda_level_out = 1'b0;
                    line_phase    = i2cbb_pkg::PH_STO_SCL_HI;
                end
                i2cbb_pkg::PH_STO_SCL_HI: begin
                    scl_level_out = 1'b1;
                    if (scl_in) line_phase = i2cbb_pkg::PH_STO_END;
                end
                i2cbb_pkg::PH_STO_END: begin
                    sda_level_out = 1'b1;
                    line_phase    = i2cbb_pkg::PH_IDLE;
                    done          = 1'b1;
                end
                i2cbb_pkg::PH_WR_SCL_LO: begin
                    scl_level_out = 1'b0;
                    line_phase    = i2cbb_pkg::PH_WR_SDA;
                end
                i2cbb_pkg::PH_WR_SDA: begin
                    // The byte rotates so that the next bit is always on top.
                    sda_level_out = |(shift_reg & i2cbb_pkg::MSB_MASK);
                    shift_reg     = {shift_reg[6:0], shift_reg[7]};
                    line_phase    = i2cbb_pkg::PH_WR_SCL_HI;
                end
                i2cbb_pkg::PH_WR_SCL_HI: begin
                    scl_level_out = 1'b1;
                    if (scl_in) begin
                        bits_moved = bits_moved + 4'd1;
                        line_phase = (bits_moved >= i2cbb_pkg::BITS_PER_BYTE) ?
                                     i2cbb_pkg::PH_WA_SCL_LO : i2cbb_pkg::PH_WR_SCL_LO;
                    end
                end
                i2cbb_pkg::PH_WA_SCL_LO: begin
                    scl_level_out = 1'b0;
                    line_phase    = i2cbb_pkg::PH_WA_SDA_HI;
                end
                i2cbb_pkg::PH_WA_SDA_HI: begin
                    sda_level_out = 1'b1;
                    line_phase    = i2cbb_pkg::PH_WA_SAMPLE;
                end
                i2cbb_pkg::PH_WA_SAMPLE: begin
                    scl_level_out = 1'b1;
                    if (scl_in) begin
                        slave_acked = ~sda_in;
                        line_phase  = i2cbb_pkg::PH_WA_END;
                    end
                end
                i2cbb_pkg::PH_WA_END: begin
                    scl_level_out = 1'b0;
                    line_phase    = i2cbb_pkg::PH_IDLE;
                    done          = 1'b1;
                end
                i2cbb_pkg::PH_RD_SDA_HI: begin
                    sda_level_out = 1'b1;
                    line_phase    = i2cbb_pkg::PH_RD_SCL_LO;
                end
                i2cbb_pkg::PH_RD_SCL_LO: begin
                    scl_level_out = 1'b0;
                    line_phase    = i2cbb_pkg::PH_RD_SAMPLE;
                end
                i2cbb_pkg::PH_RD_SAMPLE: begin
                    scl_level_out = 1'b1;
                    if (scl_in) begin
                        shift_reg  = {shift_reg[6:0], sda_in};
                        bits_moved = bits_moved + 4'd1;
                        if (bits_moved >= i2cbb_pkg::BITS_PER_BYTE) begin
                            read_latch = shift_reg;
                            line_phase = i2cbb_pkg::PH_RA_SCL_LO;
                        end else begin
                            line_phase = i2cbb_pkg::PH_RD_SCL_LO;
                        end
                    end
                end
                i2cbb_pkg::PH_RA_SCL_LO: begin
                    scl_level_out = 1'b0;
                    line_phase    = i2cbb_pkg::PH_RA_SDA;
                end
                i2cbb_pkg::PH_RA_SDA: begin
                    sda_level_out = send_nak;
                    line_phase    = i2cbb_pkg::PH_RA_SCL_HI;
                end
                i2cbb_pkg::PH_RA_SCL_HI: begin
                    scl_level_out = 1'b1;
                    if (scl_in) line_phase = i2cbb_pkg::PH_RA_SCL_LO2;
                end
                i2cbb_pkg::PH_RA_SCL_LO2: begin
                    scl_level_out = 1'b0;
                    line_phase    = i2cbb_pkg::PH_RA_END;
                end
                i2cbb_pkg::PH_RA_END: begin
                    sda_level_out = ~send_nak;
                    line_phase    = i2cbb_pkg::PH_IDLE;
                    done          = 1'b1;
                end
                default: line_phase = i2cbb_pkg::PH_IDLE;
            endcase
        end
        r.scl_drive    = scl_level_out;
        r.sda_drive    = sda_level_out;
        r.busy_res     = (line_phase != i2cbb_pkg::PH_IDLE);
        r.done_res     = done;
        r.read_byte    = read_latch;
        r.acknowledged = slave_acked;
        return r;
    endfunction

    // Reports one field that differs and flags the result as wrong.
    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] seen, inout bit wrong);
        if (want !== seen) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
            wrong = 1'b1;
        end
    endtask

    // Compare each result transaction against the oldest prediction, then predict new inputs.
    always @(posedge aclk) begin
        i2cbb_pkg::result_t want;
        i2cbb_pkg::result_t seen;
        bit                 wrong;
        if (!aresetn) begin
            line_phase    <= i2cbb_pkg::PH_IDLE;
            bits_moved    <= '0;
            shift_reg     <= '0;
            send_nak      <= 1'b0;
            scl_level_out <= 1'b1;
            sda_level_out <= 1'b1;
            slave_acked   <= 1'b0;
            read_latch    <= '0;
            line_levels_due.delete();
            pending_count <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                seen.scl_drive    = m_tdata[0];
                seen.sda_drive    = m_tdata[1];
                seen.busy_res     = m_tdata[2];
                seen.done_res     = m_tlast;
                seen.read_byte    = m_tdata[10:3];
                seen.acknowledged = m_tdata[11];
                if (line_levels_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
                    mismatch_count++;
                end else begin
                    want  = line_levels_due.pop_front();
                    wrong = 1'b0;
                    check_field("scl_drive", 8'(want.scl_drive), 8'(seen.scl_drive), wrong);
                    check_field("sda_drive", 8'(want.sda_drive), 8'(seen.sda_drive), wrong);
                    check_field("busy_res", 8'(want.busy_res), 8'(seen.busy_res), wrong);
                    check_field("done_res", 8'(want.done_res), 8'(seen.done_res), wrong);
                    check_field("read_byte", want.read_byte, seen.read_byte, wrong);
                    check_field("acknowledged", 8'(want.acknowledged),
                                8'(seen.acknowledged), wrong);
                    if (wrong) mismatch_count++;
                end
            end
            if (s_tvalid && s_tready) begin
                line_levels_due.push_back(advance_line_phase(s_tuser, s_tdata[7:0],
                                                             s_tlast, s_tdata[8],
                                                             s_tdata[9]));
            end
            pending_count <= line_levels_due.size();
        end
    end

endmodule

[sim/i2c_bitbang_master_unit_tb.sv]
// Testbench top for the I2C bit-bang master: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module i2c_bitbang_master_unit_tb;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic [2:0]  s_tuser  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;

    int mismatch_count;
    int pending_count;
    int items_sent   = 0;
    bit throttle_on  = 1'b1;

    i2c_bitbang_master_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    i2c_line_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    // Free-running 100 MHz clock.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Random back-pressure on the result channel while throttling is on.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= throttle_on ? ($urandom_range(0, 99) >= 35) : 1'b1;
        end
    end

    // Presents one transaction at a falling edge and holds it until it is taken.
    task automatic push_item(input logic [2:0] act, input logic [7:0] wbyte,
                             input logic last, input logic scl_in, input logic sda_in);
        while (throttle_on && $urandom_range(0, 99) < 35) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b000000, sda_in, scl_in, wbyte};
        s_tuser  <= act;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        items_sent++;
    endtask

    // Issues a command followed by ticks. Stretching adds extra ticks with the clock held
    // low; noise swaps ticks for random actions. A data line choice of 2 means random.
    task automatic run_command(input logic [2:0] act, input logic [7:0] wbyte,
                               input logic last, input int ticks, input int stretch_pct,
                               input int sda_sel, input int noise_pct);
        logic sda_in;
        logic [2:0] tick_act;
        push_item(act, wbyte, last, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        for (int i = 0; i < ticks; i++) begin
            sda_in = (sda_sel == 2) ? 1'($urandom_range(0, 1)) : 1'(sda_sel);
            if ($urandom_range(0, 99) < stretch_pct) begin
                push_item(i2cbb_pkg::ACT_TICK, 8'($urandom), 1'($urandom_range(0, 1)), 1'b0,
                          sda_in);
            end
            tick_act = ($urandom_range(0, 99) < noise_pct) ? 3'($urandom_range(0, 7))
                                                           : i2cbb_pkg::ACT_TICK;
            push_item(tick_act, 8'($urandom), 1'($urandom_range(0, 1)), 1'b1, sda_in);
        end
    endtask

    // Stimulus: reset, directed sequences, then random command traffic.
    initial begin
        int rand_goal;
        int pick;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Ticks and unknown codes while idle change nothing.
        push_item(i2cbb_pkg::ACT_TICK, 8'hFF, 1'b1, 1'b0, 1'b0);
        push_item(i2cbb_pkg::ACT_TICK, 8'h00, 1'b0, 1'b1, 1'b1);
        push_item(3'd5, 8'h5A, 1'b0, 1'b1, 1'b0);
        push_item(3'd6, 8'hA5, 1'b1, 1'b0, 1'b1);
        push_item(3'd7, 8'hFF, 1'b1, 1'b1, 1'b1);

        // Start, byte writes at both extremes with ACK and NAK, reads at both extremes.
        run_command(i2cbb_pkg::ACT_START, 8'h00, 1'b0, 5, 0, 2, 0);
        run_command(i2cbb_pkg::ACT_WRITE, 8'hFF, 1'b0, 28, 0, 0, 0);
        run_command(i2cbb_pkg::ACT_WRITE, 8'h00, 1'b1, 28, 0, 1, 0);
        run_command(i2cbb_pkg::ACT_READ, 8'h00, 1'b0, 23, 0, 1, 0);
        run_command(i2cbb_pkg::ACT_READ, 8'hFF, 1'b1, 23, 0, 0, 0);

        // Random clock stretching on the ticks, and commands issued while busy.
        run_command(i2cbb_pkg::ACT_WRITE, 8'hA5, 1'b0, 28, 60, 2, 0);
        run_command(i2cbb_pkg::ACT_READ, 8'h3C, 1'b0, 23, 60, 2, 30);
        run_command(i2cbb_pkg::ACT_STOP, 8'h00, 1'b0, 4, 60, 2, 0);

        // Mostly well-formed transfers; a quiet stretch without any throttling.
        rand_goal = items_sent + 600;
        while (items_sent < rand_goal) begin
            throttle_on = !(items_sent > rand_goal - 500 && items_sent < rand_goal - 350);
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                run_command(i2cbb_pkg::ACT_START, 8'($urandom), 1'($urandom_range(0, 1)),
                            5 + $urandom_range(0, 2), 10, 2, 0);
            end else if (pick < 27) begin
                run_command(i2cbb_pkg::ACT_STOP, 8'($urandom), 1'($urandom_range(0, 1)),
                            4 + $urandom_range(0, 2), 10, 2, 0);
            end else if (pick < 55) begin
                run_command(i2cbb_pkg::ACT_WRITE, 8'($urandom), 1'($urandom_range(0, 1)),
                            28 + $urandom_range(0, 3), 10, 2, 0);
            end else if (pick < 85) begin
                run_command(i2cbb_pkg::ACT_READ, 8'($urandom), 1'($urandom_range(0, 1)),
                            23 + $urandom_range(0, 3), 10, 2, 0);
            end else begin
                run_command(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom_range(0, 1)),
                            $urandom_range(0, 12), 20, 2, 40);
            end
        end
        s_tvalid <= 1'b0;
        throttle_on = 1'b1;

        // Drain the results, then let the output stage settle before the verdict.
        while (pending_count != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #5ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
